// ===== sv/ffba_pkg.sv =====
// Shared types and codes for the first-fit bump block allocator.
`default_nettype none

package ffba_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EXHAUSTED = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_MISMATCH  = 3'd4;

   localparam logic [16:0] POOL_BYTES_RESET = 17'h10000;

   typedef struct packed {
      logic        op;
      logic [16:0] req_size;
      logic [3:0]  align_log2;
      logic [15:0] free_offset;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] block_offset;
      logic [16:0] bytes_in_use;
   } rsp_item_type;

   typedef struct packed {
      logic [16:0] offset;
      logic [16:0] size;
      logic        free;
   } tbl_entry_type;

endpackage

`default_nettype wire

// ===== sv/ffba_table.sv =====
// Block table memory: one write port, one read port, registered read data.
`default_nettype none

module ffba_table
   import ffba_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire tbl_entry_type wr_data,
   input  wire logic [IDX_W-1:0] rd_addr,
   output tbl_entry_type      rd_data
);

   tbl_entry_type mem [DEPTH];
   tbl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ffba_seq.sv =====
// Request sequencer: table scan, tail carve and result register.
`default_nettype none

module ffba_seq
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS     = 64,
   parameter int POOL_ADDR_BITS = 16,
   parameter int IDX_W          = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_item_type     req_data,
   input  wire logic [16:0]      pool_bytes,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_data,
   output logic                  tbl_we,
   output logic [IDX_W-1:0]      tbl_waddr,
   output tbl_entry_type         tbl_wdata,
   output logic [IDX_W-1:0]      tbl_raddr,
   input  wire tbl_entry_type    tbl_rdata
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int AW    = 20;
   localparam logic [AW-1:0] ADDR_CAP =
      (POOL_ADDR_BITS >= AW) ? {AW{1'b1}} : (AW'(1) << POOL_ADDR_BITS);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_ALIGN,
      S_CHECK
   } state_type;

   state_type        state_ff;
   req_item_type     req_ff;
   logic [CNT_W-1:0] scan_idx_ff;
   logic [CNT_W-1:0] count_ff;
   logic [16:0]      tail_ff;
   logic [AW-1:0]    aligned_ff;
   logic [AW-1:0]    usable_ff;
   logic             rsp_strobe_ff;
   rsp_item_type     rsp_data_ff;

   logic [AW-1:0]    amask;
   logic             align_ok;
   logic             alloc_hit;
   logic             free_hit;
   logic             size_eq;
   logic             in_table;
   logic [AW-1:0]    end_sum;
   logic             tail_fail;
   logic             table_full;
   logic [CNT_W-1:0] next_idx;

   always_comb begin
      amask      = (AW'(1) << req_ff.align_log2) - AW'(1);
      align_ok   = ((AW'(tbl_rdata.offset) & amask) == '0);
      alloc_hit  = tbl_rdata.free && (tbl_rdata.size >= req_ff.req_size) && align_ok;
      free_hit   = (tbl_rdata.offset == {1'b0, req_ff.free_offset});
      size_eq    = (tbl_rdata.size == req_ff.req_size);
      in_table   = (scan_idx_ff < count_ff);
      end_sum    = aligned_ff + AW'(req_ff.req_size);
      tail_fail  = (end_sum > usable_ff) || (aligned_ff >= ADDR_CAP);
      table_full = (count_ff >= MAX_CNT);
      next_idx   = scan_idx_ff + CNT_W'(1);
   end

   always_comb begin
      tbl_raddr = (state_ff == S_IDLE) ? '0 : next_idx[IDX_W-1:0];
      tbl_we    = 1'b0;
      tbl_waddr = scan_idx_ff[IDX_W-1:0];
      tbl_wdata = tbl_rdata;
      case (state_ff)
         S_SCAN: begin
            if (in_table) begin
               if (req_ff.op == OP_ALLOC) begin
                  tbl_we         = alloc_hit;
                  tbl_wdata.free = 1'b0;
               end else begin
                  tbl_we         = free_hit && size_eq;
                  tbl_wdata.free = 1'b1;
               end
            end
         end
         S_CHECK: begin
            tbl_we           = !tail_fail && !table_full;
            tbl_waddr        = count_ff[IDX_W-1:0];
            tbl_wdata.offset = aligned_ff[16:0];
            tbl_wdata.size   = req_ff.req_size;
            tbl_wdata.free   = 1'b0;
         end
         default: begin
            tbl_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
         tail_ff       <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff      <= req_data;
                  scan_idx_ff <= '0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (!in_table) begin
                  if (req_ff.op == OP_ALLOC) begin
                     state_ff <= S_ALIGN;
                  end else begin
                     rsp_strobe_ff            <= 1'b1;
                     rsp_data_ff.status       <= STATUS_NOT_FOUND;
                     rsp_data_ff.block_offset <= '0;
                     rsp_data_ff.bytes_in_use <= tail_ff;
                     state_ff                 <= S_IDLE;
                  end
               end else if (req_ff.op == OP_ALLOC) begin
                  if (alloc_hit) begin
                     rsp_strobe_ff            <= 1'b1;
                     rsp_data_ff.status       <= STATUS_OK;
                     rsp_data_ff.block_offset <= tbl_rdata.offset[15:0];
                     rsp_data_ff.bytes_in_use <= tail_ff;
                     state_ff                 <= S_IDLE;
                  end else begin
                     scan_idx_ff <= next_idx;
                  end
               end else begin
                  if (free_hit) begin
                     rsp_strobe_ff            <= 1'b1;
                     rsp_data_ff.status       <= size_eq ? STATUS_OK : STATUS_MISMATCH;
                     rsp_data_ff.block_offset <= '0;
                     rsp_data_ff.bytes_in_use <= tail_ff;
                     state_ff                 <= S_IDLE;
                  end else begin
                     scan_idx_ff <= next_idx;
                  end
               end
            end
            S_ALIGN: begin
               aligned_ff <= (AW'(tail_ff) + amask) & ~amask;
               usable_ff  <= (AW'(pool_bytes) < ADDR_CAP) ? AW'(pool_bytes) : ADDR_CAP;
               state_ff   <= S_CHECK;
            end
            S_CHECK: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
               if (tail_fail) begin
                  rsp_data_ff.status       <= STATUS_EXHAUSTED;
                  rsp_data_ff.block_offset <= '0;
                  rsp_data_ff.bytes_in_use <= tail_ff;
               end else if (table_full) begin
                  rsp_data_ff.status       <= STATUS_FULL;
                  rsp_data_ff.block_offset <= '0;
                  rsp_data_ff.bytes_in_use <= tail_ff;
               end else begin
                  count_ff                 <= count_ff + CNT_W'(1);
                  tail_ff                  <= end_sum[16:0];
                  rsp_data_ff.status       <= STATUS_OK;
                  rsp_data_ff.block_offset <= aligned_ff[15:0];
                  rsp_data_ff.bytes_in_use <= end_sum[16:0];
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/first_fit_bump_block_allocator.sv =====
// Top level of the first-fit bump block allocator with its APB register.
//
//   port group   direction   handshake                    beat
//   req_data     in          start & !busy                one request
//   rsp_data     out         rsp_strobe (one cycle)       one result
//   apb          in/out      psel & penable & pready      pool_bytes
//
// A request scans the block table one entry per cycle through the table
// memory's read port. A hit ends the scan; a free that misses every entry
// returns NOT_FOUND, and an alloc that misses goes on to the ALIGN and CHECK tail carve.
// busy is high from accept until the result.
// Reset clears the entry count, the tail and pool_bytes to 65536; the table
// itself needs no clearing. The receiver cannot stall; results never wait.
`default_nettype none

module first_fit_bump_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS     = 64,
   parameter int POOL_ADDR_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_data,
   output logic              rsp_strobe,
   output rsp_item_type      rsp_data,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [16:0]   pool_ff;
   logic          tbl_we;
   logic [IDX_W-1:0] tbl_waddr;
   logic [IDX_W-1:0] tbl_raddr;
   tbl_entry_type tbl_wdata;
   tbl_entry_type tbl_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= POOL_BYTES_RESET;
      end else if (psel && penable && pwrite && pready && !paddr[2]) begin
         pool_ff <= pwdata[16:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? '0 : {15'd0, pool_ff};

   ffba_seq #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .POOL_ADDR_BITS (POOL_ADDR_BITS),
      .IDX_W          (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .pool_bytes (pool_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .tbl_we     (tbl_we),
      .tbl_waddr  (tbl_waddr),
      .tbl_wdata  (tbl_wdata),
      .tbl_raddr  (tbl_raddr),
      .tbl_rdata  (tbl_rdata)
   );

   ffba_table #(
      .DEPTH (MAX_BLOCKS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

endmodule

`default_nettype wire

// ===== sv/ffba_checker.sv =====
// Port-level checks on the allocator's request and result sequencing.
`default_nettype none

module ffba_checker
   import ffba_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         rsp_strobe,
   input wire rsp_item_type rsp_data
);

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_done_strobe : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_strobe_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result without a request in flight");

   a_fail_offset : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != STATUS_OK)) |-> (rsp_data.block_offset == '0))
      else $error("failed request returned a nonzero offset");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status <= STATUS_MISMATCH))
      else $error("status code out of range");

endmodule

bind first_fit_bump_block_allocator ffba_checker u_ffba_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
